// ===== rtl/clb_pkg.sv =====
// Package for the clipped line rasterizer with max blend.
// Holds shared constants, register indexes, the controller state type and the
// command and status bundles. No dependencies.
package clb_pkg;

    // Default geometry, handed to the top level as parameter defaults.
    localparam int DEF_MAX_WIDTH  = 128;
    localparam int DEF_MAX_HEIGHT = 128;
    localparam int DEF_COORD_BITS = 12;

    // Fixed field widths.
    localparam int CFG_BITS      = 8;
    localparam int CFG_ADDR_BITS = 1;
    localparam int SHADE_BITS    = 8;
    localparam int PIXEL_BITS    = 8;

    localparam logic [CFG_BITS-1:0] FRAME_SIZE_RESET = 8'd128;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_BITS-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_FRAME_HEIGHT = 1'b1;

    // Function codes carried in the input tuser.
    localparam logic FUNC_READ = 1'b1;

    // Controller states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SETUP,
        ST_DRAW,
        ST_READ,
        ST_RESP
    } clb_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture the input beat
        logic setup;     // compute line deltas and the initial error term
        logic step;      // advance the line walker by one pixel
        logic px_issue;  // issue a read-modify-write of the current pixel
        logic rd_issue;  // issue a plain read of the current pixel
        logic out_load;  // load the result register
    } clb_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_busy;  // frame store clearing pass still running
        logic at_end;      // walker sits on the line end point
        logic is_read;     // captured item is a pixel read
    } clb_status_t;

endpackage

// ===== rtl/clb_ctrl.sv =====
// Controller state machine of the line rasterizer.
// Sequences clearing, draw walks, pixel reads and the result handshake.
// Depends on clb_pkg.
module clb_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  clb_pkg::clb_status_t status,
    output clb_pkg::clb_cmd_t    cmd
);
    import clb_pkg::*;

    clb_state_t state_reg;
    clb_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    // State and result-valid registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and commands.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                if (!status.clear_busy) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP: begin
                cmd.setup = 1'b1;
                if (status.is_read) begin
                    state_next = ST_READ;
                end else begin
                    state_next = ST_DRAW;
                end
            end
            ST_READ: begin
                cmd.rd_issue = 1'b1;
                state_next   = ST_RESP;
            end
            ST_DRAW: begin
                // The last pixel's write lands during the response cycle.
                cmd.px_issue = 1'b1;
                if (status.at_end) begin
                    state_next = ST_RESP;
                end else begin
                    cmd.step = 1'b1;
                end
            end
            ST_RESP: begin
                if (!out_valid_reg || out_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // The result register holds its beat until the sink takes it.
    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== rtl/clb_line_dp.sv =====
// Line walker datapath: endpoint registers, Bresenham error term and the
// clipping test and store address of the current pixel. Depends on clb_pkg.
module clb_line_dp #(
    parameter int MAX_WIDTH  = clb_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = clb_pkg::DEF_MAX_HEIGHT,
    parameter int COORD_BITS = clb_pkg::DEF_COORD_BITS,
    localparam int ADDR_BITS = $clog2(MAX_WIDTH * MAX_HEIGHT)
) (
    input  logic                              aclk,
    input  clb_pkg::clb_cmd_t                 cmd,
    input  logic                              in_func,
    input  logic signed [COORD_BITS-1:0]      in_start_x,
    input  logic signed [COORD_BITS-1:0]      in_start_y,
    input  logic signed [COORD_BITS-1:0]      in_end_x,
    input  logic signed [COORD_BITS-1:0]      in_end_y,
    input  logic [clb_pkg::SHADE_BITS-1:0]    in_shade,
    input  logic [clb_pkg::CFG_BITS-1:0]      active_w,
    input  logic [clb_pkg::CFG_BITS-1:0]      active_h,
    output logic                              at_end,
    output logic                              is_read,
    output logic [ADDR_BITS-1:0]              pix_addr,
    output logic                              pix_inside,
    output logic [clb_pkg::SHADE_BITS-1:0]    shade
);
    import clb_pkg::*;

    localparam int D_BITS   = COORD_BITS + 1;
    localparam int E_BITS   = COORD_BITS + 3;
    localparam int X_BITS   = $clog2(MAX_WIDTH);
    localparam int Y_BITS   = $clog2(MAX_HEIGHT);
    localparam int CMP_BITS = (COORD_BITS - 1 > CFG_BITS) ? COORD_BITS - 1 : CFG_BITS;
    localparam int XY_BITS  = (X_BITS > Y_BITS) ? X_BITS : Y_BITS;
    localparam int EXT_BITS = (COORD_BITS > XY_BITS) ? COORD_BITS : XY_BITS;
    localparam logic [COORD_BITS-1:0] COORD_ONE = 1;

    logic signed [COORD_BITS-1:0] x_reg;
    logic signed [COORD_BITS-1:0] y_reg;
    logic signed [COORD_BITS-1:0] xe_reg;
    logic signed [COORD_BITS-1:0] ye_reg;
    logic [SHADE_BITS-1:0]        shade_reg;
    logic                         func_reg;
    logic signed [D_BITS-1:0]     dx_reg;
    logic signed [D_BITS-1:0]     dy_reg;
    logic                         stepx_reg;
    logic                         stepy_reg;
    logic signed [E_BITS-1:0]     err_reg;

    logic signed [D_BITS-1:0]     diff_x;
    logic signed [D_BITS-1:0]     diff_y;
    logic signed [D_BITS-1:0]     abs_x;
    logic signed [D_BITS-1:0]     abs_y;
    logic signed [E_BITS-1:0]     err_init;
    logic signed [E_BITS-1:0]     twice;
    logic signed [E_BITS-1:0]     dx_e;
    logic signed [E_BITS-1:0]     dy_e;
    logic                         move_x;
    logic                         move_y;
    logic signed [E_BITS-1:0]     err_next;
    logic signed [COORD_BITS-1:0] x_next;
    logic signed [COORD_BITS-1:0] y_next;
    logic [EXT_BITS-1:0]          x_ext;
    logic [EXT_BITS-1:0]          y_ext;
    logic                         x_inside;
    logic                         y_inside;

    // Deltas: dx is |end_x - x|, dy is -|end_y - y|.
    always_comb begin
        diff_x   = D_BITS'(xe_reg) - D_BITS'(x_reg);
        diff_y   = D_BITS'(ye_reg) - D_BITS'(y_reg);
        abs_x    = diff_x[D_BITS-1] ? -diff_x : diff_x;
        abs_y    = diff_y[D_BITS-1] ? -diff_y : diff_y;
        err_init = E_BITS'(abs_x) - E_BITS'(abs_y);
    end

    // One Bresenham step; both axes may move in the same cycle.
    always_comb begin
        twice    = err_reg <<< 1;
        dx_e     = E_BITS'(dx_reg);
        dy_e     = E_BITS'(dy_reg);
        move_x   = (twice >= dy_e);
        move_y   = (twice <= dx_e);
        err_next = err_reg + (move_x ? dy_e : E_BITS'(0)) + (move_y ? dx_e : E_BITS'(0));
        x_next   = x_reg;
        y_next   = y_reg;
        if (move_x) begin
            x_next = stepx_reg ? x_reg + COORD_ONE : x_reg - COORD_ONE;
        end
        if (move_y) begin
            y_next = stepy_reg ? y_reg + COORD_ONE : y_reg - COORD_ONE;
        end
    end

    // Endpoint, walker and error registers.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            x_reg     <= in_start_x;
            y_reg     <= in_start_y;
            xe_reg    <= in_end_x;
            ye_reg    <= in_end_y;
            shade_reg <= in_shade;
            func_reg  <= in_func;
        end else if (cmd.step) begin
            x_reg   <= x_next;
            y_reg   <= y_next;
            err_reg <= err_next;
        end
        if (cmd.setup) begin
            dx_reg    <= abs_x;
            dy_reg    <= -abs_y;
            stepx_reg <= !diff_x[D_BITS-1] && (diff_x != '0);
            stepy_reg <= !diff_y[D_BITS-1] && (diff_y != '0);
            err_reg   <= err_init;
        end
    end

    // Clipping test against the active frame and the row-major store address.
    always_comb begin
        x_inside   = !x_reg[COORD_BITS-1]
                     && (CMP_BITS'(x_reg[COORD_BITS-2:0]) < CMP_BITS'(active_w));
        y_inside   = !y_reg[COORD_BITS-1]
                     && (CMP_BITS'(y_reg[COORD_BITS-2:0]) < CMP_BITS'(active_h));
        pix_inside = x_inside && y_inside;
        x_ext      = EXT_BITS'(x_reg);
        y_ext      = EXT_BITS'(y_reg);
        pix_addr   = ADDR_BITS'(y_ext[Y_BITS-1:0]) * ADDR_BITS'(MAX_WIDTH)
                     + ADDR_BITS'(x_ext[X_BITS-1:0]);
    end

    assign at_end  = (x_reg == xe_reg) && (y_reg == ye_reg);
    assign is_read = (func_reg == FUNC_READ);
    assign shade   = shade_reg;

endmodule

// ===== rtl/clb_frame_mem.sv =====
// Frame store with a two-stage read-modify-write max blend, a read port for
// pixel reads and the clearing pass after reset. Depends on clb_pkg.
module clb_frame_mem #(
    parameter int MAX_WIDTH  = clb_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = clb_pkg::DEF_MAX_HEIGHT,
    localparam int DEPTH     = MAX_WIDTH * MAX_HEIGHT,
    localparam int ADDR_BITS = $clog2(DEPTH)
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  clb_pkg::clb_cmd_t              cmd,
    input  logic [ADDR_BITS-1:0]           pix_addr,
    input  logic                           pix_inside,
    input  logic [clb_pkg::SHADE_BITS-1:0] shade,
    output logic [clb_pkg::PIXEL_BITS-1:0] rd_data,
    output logic                           rd_inside,
    output logic                           clear_busy
);
    import clb_pkg::*;

    logic [PIXEL_BITS-1:0] frame_store_mem [DEPTH];

    logic [PIXEL_BITS-1:0] rd_data_reg;
    logic                  rd_inside_reg;
    logic                  wr_pend_reg;
    logic [ADDR_BITS-1:0]  wr_addr_reg;
    logic                  clear_busy_reg;
    logic [ADDR_BITS-1:0]  clr_addr_reg;

    logic                  wr_en;
    logic [ADDR_BITS-1:0]  wr_addr;
    logic [PIXEL_BITS-1:0] wr_data;

    // Write port: the clearing pass, or the blend stage when the line is brighter.
    always_comb begin
        if (clear_busy_reg) begin
            wr_en   = 1'b1;
            wr_addr = clr_addr_reg;
            wr_data = '0;
        end else begin
            wr_en   = wr_pend_reg && (rd_data_reg < shade);
            wr_addr = wr_addr_reg;
            wr_data = shade;
        end
    end

    // Store write and registered read. Consecutive pixels of one line differ,
    // so a read never meets the pending write at the same address.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            frame_store_mem[wr_addr] <= wr_data;
        end
        if (cmd.px_issue || cmd.rd_issue) begin
            rd_data_reg   <= frame_store_mem[pix_addr];
            rd_inside_reg <= pix_inside;
            wr_addr_reg   <= pix_addr;
        end
    end

    // Blend pending flag and the clearing sweep.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_pend_reg    <= 1'b0;
            clear_busy_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end else begin
            wr_pend_reg <= cmd.px_issue && pix_inside;
            if (clear_busy_reg) begin
                if (clr_addr_reg == ADDR_BITS'(DEPTH - 1)) begin
                    clear_busy_reg <= 1'b0;
                end else begin
                    clr_addr_reg <= clr_addr_reg + ADDR_BITS'(1);
                end
            end
        end
    end

    assign rd_data    = rd_data_reg;
    assign rd_inside  = rd_inside_reg;
    assign clear_busy = clear_busy_reg;

endmodule

// ===== rtl/clipped_line_raster_max_blend.sv =====
// Top level of the clipped line rasterizer with max blend.
// Instantiates clb_ctrl, clb_line_dp and clb_frame_mem; depends on clb_pkg.
//
// The block owns a MAX_WIDTH x MAX_HEIGHT frame store of 8-bit pixels with a
// row stride of MAX_WIDTH. After reset a clearing pass zeroes the store one
// pixel per cycle, and s_tready stays low until it ends; configuration writes
// are taken throughout. A draw beat walks a Bresenham line from start to end
// point, one pixel per cycle through a pipelined read-modify-write of the
// store, and blends the shade into every pixel inside the active frame by
// taking the maximum. After acceptance a beat passes a setup state, then the
// line walk for a draw or one store read for a pixel read, then a response
// state that loads the result register once it is empty or being taken. One
// item is in flight at a time, and the next beat is accepted while the
// previous result still waits in the output register.
// Widths above MAX_WIDTH or heights above MAX_HEIGHT act as the maximum.
module clipped_line_raster_max_blend #(
    parameter int MAX_WIDTH  = clb_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = clb_pkg::DEF_MAX_HEIGHT,
    parameter int COORD_BITS = clb_pkg::DEF_COORD_BITS,
    localparam int S_DATA_BITS = ((4 * COORD_BITS + clb_pkg::SHADE_BITS + 7) / 8) * 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Input channel.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // tdata from bit 0: start_x, start_y, end_x, end_y, shade, zero padding.
    input  logic [S_DATA_BITS-1:0]            s_tdata,
    // tuser: func.
    input  logic                              s_tuser,
    // Result channel.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // tdata: pixel_value.
    output logic [clb_pkg::PIXEL_BITS-1:0]    m_tdata,
    // tuser: inside_frame.
    output logic                              m_tuser,
    // Configuration write port.
    input  logic                              cfg_wen,
    input  logic [clb_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
    input  logic [clb_pkg::CFG_BITS-1:0]      cfg_wdata
);
    import clb_pkg::*;

    localparam int ADDR_BITS = $clog2(MAX_WIDTH * MAX_HEIGHT);

    logic [CFG_BITS-1:0]   frame_width_reg;
    logic [CFG_BITS-1:0]   frame_height_reg;
    logic [CFG_BITS-1:0]   active_w;
    logic [CFG_BITS-1:0]   active_h;
    logic [PIXEL_BITS-1:0] pixel_value_reg;
    logic                  inside_frame_reg;

    clb_cmd_t              cmd;
    clb_status_t           status;
    logic                  at_end;
    logic                  is_read;
    logic [ADDR_BITS-1:0]  pix_addr;
    logic                  pix_inside;
    logic [SHADE_BITS-1:0] shade;
    logic [PIXEL_BITS-1:0] rd_data;
    logic                  rd_inside;
    logic                  clear_busy;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= FRAME_SIZE_RESET;
            frame_height_reg <= FRAME_SIZE_RESET;
        end else if (cfg_wen) begin
            case (cfg_addr)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_wdata;
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Frame size saturates at the store dimensions.
    assign active_w = (int'(frame_width_reg) > MAX_WIDTH) ? CFG_BITS'(MAX_WIDTH)
                                                           : frame_width_reg;
    assign active_h = (int'(frame_height_reg) > MAX_HEIGHT) ? CFG_BITS'(MAX_HEIGHT)
                                                             : frame_height_reg;

    assign status.clear_busy = clear_busy;
    assign status.at_end     = at_end;
    assign status.is_read    = is_read;

    clb_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .status    (status),
        .cmd       (cmd)
    );

    clb_line_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .COORD_BITS (COORD_BITS)
    ) u_line_dp (
        .aclk       (aclk),
        .cmd        (cmd),
        .in_func    (s_tuser),
        .in_start_x (s_tdata[0*COORD_BITS +: COORD_BITS]),
        .in_start_y (s_tdata[1*COORD_BITS +: COORD_BITS]),
        .in_end_x   (s_tdata[2*COORD_BITS +: COORD_BITS]),
        .in_end_y   (s_tdata[3*COORD_BITS +: COORD_BITS]),
        .in_shade   (s_tdata[4*COORD_BITS +: SHADE_BITS]),
        .active_w   (active_w),
        .active_h   (active_h),
        .at_end     (at_end),
        .is_read    (is_read),
        .pix_addr   (pix_addr),
        .pix_inside (pix_inside),
        .shade      (shade)
    );

    clb_frame_mem #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_frame_mem (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .pix_addr   (pix_addr),
        .pix_inside (pix_inside),
        .shade      (shade),
        .rd_data    (rd_data),
        .rd_inside  (rd_inside),
        .clear_busy (clear_busy)
    );

    // Result register; a draw reports zero and outside.
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            pixel_value_reg  <= (is_read && rd_inside) ? rd_data : '0;
            inside_frame_reg <= is_read && rd_inside;
        end
    end

    assign m_tdata = pixel_value_reg;
    assign m_tuser = inside_frame_reg;

endmodule

// ===== rtl/clb_checker.sv =====
// Port-level assertions for the line rasterizer, bound to the top level.
// Depends on the top level's ports and on clb_pkg.
module clb_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [clb_pkg::PIXEL_BITS-1:0]    m_tdata,
    input logic                              m_tuser
);

    // A stalled result beat stays valid.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat dropped while stalled");

    // A stalled result beat keeps its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result payload changed while stalled");

    // A result outside the frame, and every draw result, carries a zero pixel.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("nonzero pixel on a result outside the frame");

    // Only one item is worked on at a time.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while an item is in flight");

endmodule

bind clipped_line_raster_max_blend clb_checker u_clb_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== sim/clipped_line_raster_max_blend_tb.sv =====
// Self-checking testbench for the clipped line rasterizer with max blend.
// Drives draw and read beats, predicts every result from a local frame copy and
// checks the result stream. Depends on clb_pkg and clipped_line_raster_max_blend.
`timescale 1ns / 1ps

module clipped_line_raster_max_blend_tb;
    import clb_pkg::*;

    localparam int MAX_W       = DEF_MAX_WIDTH;
    localparam int MAX_H       = DEF_MAX_HEIGHT;
    localparam int CB          = DEF_COORD_BITS;
    localparam int S_DATA_BITS = ((4 * CB + SHADE_BITS + 7) / 8) * 8;
    localparam logic FUNC_DRAW = ~FUNC_READ;

    localparam longint LIMIT_CYCLES = 1_600_000;
    localparam int     STALL_CYCLES = 600;
    localparam int     PHASE_ITEMS  = 103;
    localparam int     NUM_SETTINGS = 11;

    typedef struct {
        logic                  func;
        logic signed [CB-1:0]  start_x;
        logic signed [CB-1:0]  start_y;
        logic signed [CB-1:0]  end_x;
        logic signed [CB-1:0]  end_y;
        logic [SHADE_BITS-1:0] shade;
    } raster_item_t;

    typedef struct packed {
        logic [PIXEL_BITS-1:0] pixel;
        logic                  in_bounds;
    } pixel_result_t;

    logic                     aclk;
    logic                     aresetn   = 1'b0;
    logic                     s_tvalid  = 1'b0;
    logic                     s_tready;
    // tdata from bit 0: start_x, start_y, end_x, end_y, shade.
    logic [S_DATA_BITS-1:0]   s_tdata   = '0;
    // tuser: func.
    logic                     s_tuser   = 1'b0;
    logic                     m_tvalid;
    logic                     m_tready  = 1'b0;
    // tdata: pixel_value.
    logic [PIXEL_BITS-1:0]    m_tdata;
    // tuser: inside_frame.
    logic                     m_tuser;
    logic                     cfg_wen   = 1'b0;
    logic [CFG_ADDR_BITS-1:0] cfg_addr  = '0;
    logic [CFG_BITS-1:0]      cfg_wdata = '0;

    // Local copy of the frame store and the active frame size.
    logic [PIXEL_BITS-1:0] frame_copy [MAX_W * MAX_H];
    int unsigned           frame_w = 128;
    int unsigned           frame_h = 128;

    raster_item_t  beats_to_send [$];
    pixel_result_t pixels_due [$];
    int            beats_queued  = 0;
    int            beats_taken   = 0;
    int            results_seen  = 0;
    int            errors        = 0;
    logic          in_took       = 1'b0;
    int            stall_left    = 0;
    int            next_stall_at = 150;

    clipped_line_raster_max_blend u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_wen  (cfg_wen),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Sizes wider or taller than the store saturate at the store size.
    function automatic int active_w();
        return (frame_w > MAX_W) ? MAX_W : int'(frame_w);
    endfunction

    function automatic int active_h();
        return (frame_h > MAX_H) ? MAX_H : int'(frame_h);
    endfunction

    function automatic bit in_frame(input int x, input int y);
        return x >= 0 && y >= 0 && x < active_w() && y < active_h();
    endfunction

    function automatic bit calm_window();
        return beats_taken >= 500 && beats_taken < 650;
    endfunction

    function automatic int near_coord();
        return int'($urandom_range(0, 171)) - 22;
    endfunction

    function automatic int full_coord();
        logic [CB-1:0] raw;
        raw = CB'($urandom);
        return int'($signed(raw));
    endfunction

    function automatic logic [S_DATA_BITS-1:0] pack_beat(input raster_item_t it);
        logic [S_DATA_BITS-1:0] packed_data;
        packed_data = '0;
        packed_data[0 * CB +: CB]     = it.start_x;
        packed_data[1 * CB +: CB]     = it.start_y;
        packed_data[2 * CB +: CB]     = it.end_x;
        packed_data[3 * CB +: CB]     = it.end_y;
        packed_data[4 * CB +: SHADE_BITS] = it.shade;
        return packed_data;
    endfunction

    // Max-blend one pixel into the local frame copy, clipped to the active frame.
    task automatic blend_pixel(input int x, input int y, input logic [SHADE_BITS-1:0] shade);
        int idx;
        if (in_frame(x, y)) begin
            idx = y * MAX_W + x;
            if (frame_copy[idx] < shade)
                frame_copy[idx] = shade;
        end
    endtask

    // Integer line walk over all octants, both end points included.
    task automatic walk_line(input int x, input int y, input int xe, input int ye,
                             input logic [SHADE_BITS-1:0] shade);
        int dx, dy, stepx, stepy, err, twice;
        bit done;
        dx    = (xe > x) ? xe - x : x - xe;
        dy    = (ye > y) ? y - ye : ye - y;
        stepx = (x < xe) ? 1 : -1;
        stepy = (y < ye) ? 1 : -1;
        err   = dx + dy;
        done  = 1'b0;
        while (!done) begin
            blend_pixel(x, y, shade);
            if (x == xe && y == ye) begin
                done = 1'b1;
            end else begin
                twice = 2 * err;
                if (twice >= dy) begin
                    err += dy;
                    x   += stepx;
                end
                if (twice <= dx) begin
                    err += dx;
                    y   += stepy;
                end
            end
        end
    endtask

    // Work out the result of one accepted beat and update the frame copy.
    task automatic rasterize_beat(input logic func, input logic [S_DATA_BITS-1:0] data,
                                  output pixel_result_t res);
        int x0, y0;
        x0  = int'($signed(data[0 * CB +: CB]));
        y0  = int'($signed(data[1 * CB +: CB]));
        res = '0;
        if (func == FUNC_DRAW) begin
            walk_line(x0, y0, int'($signed(data[2 * CB +: CB])),
                      int'($signed(data[3 * CB +: CB])), data[4 * CB +: SHADE_BITS]);
        end else if (in_frame(x0, y0)) begin
            res.pixel     = frame_copy[y0 * MAX_W + x0];
            res.in_bounds = 1'b1;
        end
    endtask

    task automatic queue_item(input logic func, input int sx, input int sy, input int ex,
                              input int ey, input int shade);
        raster_item_t it;
        it.func    = func;
        it.start_x = sx[CB-1:0];
        it.start_y = sy[CB-1:0];
        it.end_x   = ex[CB-1:0];
        it.end_y   = ey[CB-1:0];
        it.shade   = shade[SHADE_BITS-1:0];
        beats_to_send.push_back(it);
        beats_queued++;
    endtask

    // Random mix: reads aimed at the active frame, noise reads, a few full-range
    // lines, and mostly lines around the frame so that clipping is exercised.
    task automatic queue_random(input int count);
        int k, pick, x0, y0, x1, y1;
        for (k = 0; k < count; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                if (active_w() > 0 && active_h() > 0 && $urandom_range(0, 3) != 0) begin
                    x0 = $urandom_range(0, active_w() - 1);
                    y0 = $urandom_range(0, active_h() - 1);
                end else begin
                    x0 = near_coord();
                    y0 = near_coord();
                end
                queue_item(FUNC_READ, x0, y0, full_coord(), full_coord(),
                           $urandom_range(0, 255));
            end else if (pick < 38) begin
                queue_item(FUNC_READ, full_coord(), full_coord(), full_coord(),
                           full_coord(), $urandom_range(0, 255));
            end else if (pick < 40) begin
                queue_item(FUNC_DRAW, full_coord(), full_coord(), full_coord(),
                           full_coord(), $urandom_range(0, 255));
            end else begin
                x0 = near_coord();
                y0 = near_coord();
                if ($urandom_range(0, 1) != 0) begin
                    x1 = x0 + int'($urandom_range(0, 80)) - 40;
                    y1 = y0 + int'($urandom_range(0, 80)) - 40;
                end else begin
                    x1 = near_coord();
                    y1 = near_coord();
                end
                queue_item(FUNC_DRAW, x0, y0, x1, y1, $urandom_range(0, 255));
            end
        end
    endtask

    // Register writes happen only while nothing is in flight.
    task automatic write_reg(input logic [CFG_ADDR_BITS-1:0] idx,
                             input logic [CFG_BITS-1:0] value);
        @(negedge aclk);
        cfg_wen   <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        if (idx == REG_FRAME_WIDTH)
            frame_w = 32'(value);
        else if (idx == REG_FRAME_HEIGHT)
            frame_h = 32'(value);
        @(negedge aclk);
        cfg_wen <= 1'b0;
    endtask

    task automatic wait_drained();
        while (beats_taken != beats_queued || pixels_due.size() != 0)
            @(negedge aclk);
    endtask

    // Input driver: a beat stays offered until it is taken.
    always @(negedge aclk) begin : drive_input
        raster_item_t nxt;
        bit           gap;
        if (!s_tvalid || in_took) begin
            gap = !calm_window() && ($urandom_range(0, 99) < 28);
            if (aresetn && !gap && beats_to_send.size() != 0) begin
                nxt = beats_to_send.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= pack_beat(nxt);
                s_tuser  <= nxt.func;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result ready: random gaps plus long hold-offs that back the block up.
    always @(negedge aclk) begin : drive_ready
        bit ready_nxt;
        if (stall_left > 0) begin
            stall_left--;
            ready_nxt = 1'b0;
        end else if (results_seen >= next_stall_at) begin
            stall_left    = STALL_CYCLES - 1;
            next_stall_at += 650;
            ready_nxt     = 1'b0;
        end else begin
            ready_nxt = calm_window() || ($urandom_range(0, 99) >= 28);
        end
        m_tready <= ready_nxt;
    end

    // Predict on each accepted input beat, check each accepted result beat.
    always @(posedge aclk) begin : monitor
        pixel_result_t want;
        pixel_result_t got;
        if (aresetn && s_tvalid && s_tready) begin
            rasterize_beat(s_tuser, s_tdata, got);
            pixels_due.push_back(got);
            beats_taken++;
            in_took <= 1'b1;
        end else begin
            in_took <= 1'b0;
        end
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (pixels_due.size() == 0) begin
                errors++;
                $display("%0t: result beat with nothing expected: pixel %0d inside %0b",
                         $time, m_tdata, m_tuser);
            end else begin
                want = pixels_due.pop_front();
                if (m_tdata !== want.pixel) begin
                    errors++;
                    $display("%0t: pixel_value mismatch: expected %0d, actual %0d",
                             $time, want.pixel, m_tdata);
                end
                if (m_tuser !== want.in_bounds) begin
                    errors++;
                    $display("%0t: inside_frame mismatch: expected %0b, actual %0b",
                             $time, want.in_bounds, m_tuser);
                end
            end
        end
    end

    // Main sequence: reset, directed beats, then random phases per frame size.
    initial begin : stimulus
        int setting_w [NUM_SETTINGS] = '{128, 1, 0, 255, 0, 128, 77, 0, 128, 1, 128};
        int setting_h [NUM_SETTINGS] = '{128, 1, 0, 200, 128, 0, 33, 0, 1, 128, 128};
        int p, k;
        for (k = 0; k < MAX_W * MAX_H; k++)
            frame_copy[k] = '0;
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;

        // Writes during the clearing pass are taken.
        write_reg(REG_FRAME_WIDTH, 8'd128);
        write_reg(REG_FRAME_HEIGHT, 8'd128);

        // Directed part at the full frame size.
        queue_item(FUNC_READ, 0, 0, 0, 0, 0);
        queue_item(FUNC_READ, 127, 127, 0, 0, 0);
        queue_item(FUNC_DRAW, 0, 0, 127, 0, 255);
        queue_item(FUNC_DRAW, 0, 127, 0, 0, 1);
        // Degenerate line, then a read of that pixel.
        queue_item(FUNC_DRAW, 10, 10, 10, 10, 200);
        queue_item(FUNC_READ, 10, 10, 0, 0, 0);
        // One line into each octant from the middle.
        queue_item(FUNC_DRAW, 64, 64, 90, 70, 30);
        queue_item(FUNC_DRAW, 64, 64, 70, 90, 60);
        queue_item(FUNC_DRAW, 64, 64, 58, 90, 90);
        queue_item(FUNC_DRAW, 64, 64, 38, 70, 120);
        queue_item(FUNC_DRAW, 64, 64, 38, 58, 150);
        queue_item(FUNC_DRAW, 64, 64, 58, 38, 180);
        queue_item(FUNC_DRAW, 64, 64, 70, 38, 210);
        queue_item(FUNC_DRAW, 64, 64, 90, 58, 240);
        // A lower shade must not overwrite a brighter pixel.
        queue_item(FUNC_DRAW, 64, 64, 64, 64, 50);
        queue_item(FUNC_READ, 64, 64, 0, 0, 0);
        // Lines across the whole coordinate range, clipped to the frame.
        queue_item(FUNC_DRAW, -2048, -2048, 2047, 2047, 128);
        queue_item(FUNC_DRAW, 2047, -2048, -2048, 2047, 0);
        queue_item(FUNC_READ, 20, 20, 0, 0, 0);
        // Reads just and far outside the frame.
        queue_item(FUNC_READ, -1, 0, 0, 0, 0);
        queue_item(FUNC_READ, 128, 5, 0, 0, 0);
        queue_item(FUNC_READ, 5, 128, 0, 0, 0);
        queue_item(FUNC_READ, -2048, 2047, 0, 0, 0);
        queue_item(FUNC_READ, 2047, -2048, 0, 0, 0);
        wait_drained();

        // Random phases over a range of frame sizes, extremes included.
        for (p = 0; p < NUM_SETTINGS; p++) begin
            if (p == 7) begin
                setting_w[p] = $urandom_range(0, 255);
                setting_h[p] = $urandom_range(0, 255);
            end
            write_reg(REG_FRAME_WIDTH, setting_w[p][CFG_BITS-1:0]);
            write_reg(REG_FRAME_HEIGHT, setting_h[p][CFG_BITS-1:0]);
            queue_random(PHASE_ITEMS);
            wait_drained();
        end

        // Let any stray result show up before the verdict.
        repeat (200) @(negedge aclk);
        if (pixels_due.size() != 0) begin
            errors++;
            $display("%0t: %0d expected results never arrived", $time, pixels_due.size());
        end
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin : watchdog
        #(LIMIT_CYCLES * 8);
        $display("%0t: timeout", $time);
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/clb_pkg.sv
rtl/clb_ctrl.sv
rtl/clb_line_dp.sv
rtl/clb_frame_mem.sv
rtl/clipped_line_raster_max_blend.sv
rtl/clb_checker.sv
sim/clipped_line_raster_max_blend_tb.sv
